@@ src/carl_pkg.sv @@
// Shared types, codes and constants for the command/acknowledge retry link.
// Used by every module of the link; depends on nothing else.
`timescale 1ns / 1ps

package carl_pkg;

   localparam int SAMPLE_BITS = 12;
   localparam int LEN_BITS    = 6;
   localparam int TEXT_BITS   = 40;
   localparam int TRIES_BITS  = 8;
   localparam int TIMER_BITS  = 16;
   localparam int OP_BITS     = 2;
   localparam int EV_BITS     = 3;
   localparam int CSR_ADDR_BITS = 2;
   localparam int CSR_DATA_BITS = 16;
   localparam int REQ_DATA_BITS = 64;
   localparam int RSP_DATA_BITS = 24;

   // operation codes carried in req_tuser
   localparam logic [OP_BITS-1:0] OP_CMD  = 2'd0;
   localparam logic [OP_BITS-1:0] OP_TICK = 2'd1;
   localparam logic [OP_BITS-1:0] OP_POLL = 2'd2;

   // event codes carried in rsp_tuser
   localparam logic [EV_BITS-1:0] EV_NONE   = 3'd0;
   localparam logic [EV_BITS-1:0] EV_ACK    = 3'd1;
   localparam logic [EV_BITS-1:0] EV_REQ    = 3'd2;
   localparam logic [EV_BITS-1:0] EV_ERR    = 3'd3;
   localparam logic [EV_BITS-1:0] EV_SENT   = 3'd4;
   localparam logic [EV_BITS-1:0] EV_GIVEUP = 3'd5;
   localparam logic [EV_BITS-1:0] EV_CLOSED = 3'd6;

   // register indexes on the csr port
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TRY_LIMIT   = 2'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_FIRST_DELAY = 2'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_ACK_TIMEOUT = 2'd2;

   localparam logic [TRIES_BITS-1:0] TRY_LIMIT_RST   = 8'd3;
   localparam logic [TIMER_BITS-1:0] FIRST_DELAY_RST = 16'd10;
   localparam logic [TIMER_BITS-1:0] ACK_TIMEOUT_RST = 16'd300;

   // "!OK#" and "!RST#", byte zero in the low bits
   localparam logic [31:0]          TEXT_OK  = 32'h234B_4F21;
   localparam logic [TEXT_BITS-1:0] TEXT_RST = 40'h23_5453_5221;
   localparam logic [LEN_BITS-1:0]  LEN_OK   = 6'd4;
   localparam logic [LEN_BITS-1:0]  LEN_RST  = 6'd5;

   typedef enum logic [3:0] {
      MODE_IDLE = 4'b0001,
      MODE_SEND = 4'b0010,
      MODE_WAIT = 4'b0100,
      MODE_END  = 4'b1000
   } link_mode_type;

   typedef struct packed {
      logic [OP_BITS-1:0]     op;
      logic [LEN_BITS-1:0]    cmd_length;
      logic [TEXT_BITS-1:0]   cmd_text;
      logic [SAMPLE_BITS-1:0] adc_sample;
   } req_item_type;

   typedef struct packed {
      logic [EV_BITS-1:0]     event_res;
      logic [SAMPLE_BITS-1:0] sent_value;
      logic [TRIES_BITS-1:0]  tries_used;
   } rsp_item_type;

   typedef struct packed {
      logic [TRIES_BITS-1:0] try_limit;
      logic [TIMER_BITS-1:0] first_delay;
      logic [TIMER_BITS-1:0] ack_timeout;
   } cfg_type;

   typedef struct packed {
      logic is_ack;
      logic is_req;
   } cmd_class_type;

endpackage

@@ src/carl_decode.sv @@
// Command matcher: classifies a received command as acknowledge, request or error.
// Depends on carl_pkg.
`timescale 1ns / 1ps

module carl_decode
   import carl_pkg::*;
(
   input  logic [LEN_BITS-1:0]  cmd_length,
   input  logic [TEXT_BITS-1:0] cmd_text,
   output cmd_class_type        cmd_class
);

   // only the first cmd_length bytes count, so the ack ignores byte four
   assign cmd_class.is_ack = (cmd_length == LEN_OK) && (cmd_text[31:0] == TEXT_OK);
   assign cmd_class.is_req = (cmd_length == LEN_RST) && (cmd_text == TEXT_RST);

endmodule

@@ src/carl_engine.sv @@
// Link state machine: session state, resend counter and timeout timer.
// One item is handled per step; depends on carl_pkg and carl_decode.
`timescale 1ns / 1ps

module carl_engine
   import carl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,
   input  req_item_type item,
   input  cfg_type      cfg,
   output rsp_item_type result
);

   link_mode_type          mode_ff, mode_in;
   logic [SAMPLE_BITS-1:0] held_ff, held_in;
   logic [TRIES_BITS-1:0]  resend_ff, resend_in;
   logic [TIMER_BITS-1:0]  timer_ff, timer_in;
   logic                   expired_ff, expired_in;
   logic [TIMER_BITS-1:0]  timer_dec;
   cmd_class_type          cmd_class;

   carl_decode u_decode (
      .cmd_length (item.cmd_length),
      .cmd_text   (item.cmd_text),
      .cmd_class  (cmd_class)
   );

   assign timer_dec = timer_ff - TIMER_BITS'(1);

   always_comb begin
      mode_in           = mode_ff;
      held_in           = held_ff;
      resend_in         = resend_ff;
      timer_in          = timer_ff;
      expired_in        = expired_ff;
      result.event_res  = EV_NONE;
      result.sent_value = '0;
      if (item.op == OP_CMD) begin
         if (cmd_class.is_ack) begin
            mode_in          = MODE_END;
            result.event_res = EV_ACK;
         end else if (cmd_class.is_req) begin
            mode_in          = MODE_SEND;
            held_in          = item.adc_sample;
            timer_in         = cfg.first_delay;
            expired_in       = (cfg.first_delay == '0);
            result.event_res = EV_REQ;
         end else begin
            result.event_res = EV_ERR;
         end
      end else if (item.op == OP_TICK) begin
         if (timer_ff != '0) begin
            timer_in = timer_dec;
            if (timer_dec == '0) begin
               expired_in = 1'b1;
            end
         end
      end else if (item.op == OP_POLL) begin
         case (mode_ff)
            MODE_SEND: begin
               mode_in           = MODE_WAIT;
               result.event_res  = EV_SENT;
               result.sent_value = held_ff;
            end
            MODE_WAIT: begin
               if (expired_ff) begin
                  if (resend_ff >= cfg.try_limit) begin
                     mode_in          = MODE_END;
                     result.event_res = EV_GIVEUP;
                  end else begin
                     resend_in         = resend_ff + TRIES_BITS'(1);
                     result.event_res  = EV_SENT;
                     result.sent_value = held_ff;
                     timer_in          = cfg.ack_timeout;
                     expired_in        = (cfg.ack_timeout == '0);
                  end
               end
            end
            MODE_END: begin
               mode_in          = MODE_IDLE;
               resend_in        = '0;
               result.event_res = EV_CLOSED;
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
      result.tries_used = resend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IDLE;
         held_ff    <= '0;
         resend_ff  <= '0;
         timer_ff   <= '0;
         expired_ff <= 1'b0;
      end else if (step_en) begin
         mode_ff    <= mode_in;
         held_ff    <= held_in;
         resend_ff  <= resend_in;
         timer_ff   <= timer_in;
         expired_ff <= expired_in;
      end
   end

   // a running timer has never expired
   a_timer_expiry: assert property (@(posedge clock) disable iff (reset)
      (timer_ff != '0) |-> !expired_ff)
      else $error("timer running with expiry flag set");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.event_res == EV_CLOSED) |=> (resend_ff == '0) && (mode_ff == MODE_IDLE))
      else $error("session close left tries or mode behind");

   a_sent_value: assert property (@(posedge clock) disable iff (reset)
      (step_en && result.event_res == EV_SENT) |-> (result.sent_value == held_ff))
      else $error("sent value differs from latched sample");

   a_hold_state: assert property (@(posedge clock) disable iff (reset)
      !step_en |=> $stable(mode_ff) && $stable(resend_ff) && $stable(timer_ff))
      else $error("state moved without a step");

endmodule

@@ src/command_ack_retry_link.sv @@
// Stop-and-wait sender with acknowledge timeout and bounded resends.
// Path: a transferred request passes the input register and then the result register to rsp_tvalid.
// Throughput: one item per cycle; one result per item, stalled only by rsp_tready.
// The input register takes a new item while a finished result waits in the result register.
// Reset (synchronous, active high): link idle, timer and tries cleared,
// registers back to try_limit 3, first_delay 10, ack_timeout 300.
`timescale 1ns / 1ps

module command_ack_retry_link
   import carl_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,  // cmd_length, cmd_text, adc_sample, zero pad
   input  logic [OP_BITS-1:0]        req_tuser,  // op
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,  // sent_value, tries_used, zero pad
   output logic [EV_BITS-1:0]        rsp_tuser,  // event_res
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   localparam int LEN_LO    = 0;
   localparam int TEXT_LO   = LEN_LO + LEN_BITS;
   localparam int SAMPLE_LO = TEXT_LO + TEXT_BITS;

   logic         in_valid_ff;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type step_result;
   cfg_type      cfg_ff;
   logic         advance;
   logic         req_xfer;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign in_item_in.op         = req_tuser;
   assign in_item_in.cmd_length = req_tdata[LEN_LO +: LEN_BITS];
   assign in_item_in.cmd_text   = req_tdata[TEXT_LO +: TEXT_BITS];
   assign in_item_in.adc_sample = req_tdata[SAMPLE_LO +: SAMPLE_BITS];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff <= in_item_in;
      end
   end

   carl_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (in_item_ff),
      .cfg     (cfg_ff),
      .result  (step_result)
   );

   // hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.event_res;
   assign rsp_tdata  = {{(RSP_DATA_BITS - SAMPLE_BITS - TRIES_BITS){1'b0}},
                        out_item_ff.tries_used, out_item_ff.sent_value};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.try_limit   <= TRY_LIMIT_RST;
         cfg_ff.first_delay <= FIRST_DELAY_RST;
         cfg_ff.ack_timeout <= ACK_TIMEOUT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TRY_LIMIT:   cfg_ff.try_limit   <= csr_data[TRIES_BITS-1:0];
            CSR_FIRST_DELAY: cfg_ff.first_delay <= csr_data[TIMER_BITS-1:0];
            CSR_ACK_TIMEOUT: cfg_ff.ack_timeout <= csr_data[TIMER_BITS-1:0];
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for command_ack_retry_link: directed sessions, resend exhaustion
// and random traffic under idling and backpressure, checked against a local predictor.
// Depends on carl_pkg and the command_ack_retry_link top level in src.
`timescale 1ns / 1ps

module testbench;
   import carl_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 50;
   localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SPARE = 2'd3;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [OP_BITS-1:0]       req_tuser = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [EV_BITS-1:0]       rsp_tuser;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_ADDR_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   // predictor state and register copy
   link_mode_type           pred_mode;
   logic [SAMPLE_BITS-1:0]  pred_sample;
   logic [TRIES_BITS-1:0]   pred_resends;
   logic [TIMER_BITS-1:0]   pred_timer;
   logic                    pred_expired;
   cfg_type                 pred_cfg;

   rsp_item_type expected_events[$];
   int fail_count = 0;
   int cycle_count = 0;
   int gap_pct = 0;
   int stall_pct = 0;

   command_ack_retry_link u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_events.size());
         $display("FAILURE");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99, 0) >= stall_pct);
   end

   function automatic rsp_item_type next_link_event(input req_item_type it);
      rsp_item_type r;
      r = '0;
      r.event_res = EV_NONE;
      case (it.op)
         OP_CMD: begin
            if (it.cmd_length == LEN_OK && it.cmd_text[31:0] == TEXT_OK) begin
               pred_mode = MODE_END;
               r.event_res = EV_ACK;
            end else if (it.cmd_length == LEN_RST && it.cmd_text == TEXT_RST) begin
               pred_mode = MODE_SEND;
               pred_sample = it.adc_sample;
               pred_timer = pred_cfg.first_delay;
               pred_expired = (pred_cfg.first_delay == '0);
               r.event_res = EV_REQ;
            end else begin
               r.event_res = EV_ERR;
            end
         end
         OP_TICK: begin
            if (pred_timer != '0) begin
               pred_timer = pred_timer - 1'b1;
               if (pred_timer == '0) pred_expired = 1'b1;
            end
         end
         OP_POLL: begin
            case (pred_mode)
               MODE_SEND: begin
                  pred_mode = MODE_WAIT;
                  r.event_res = EV_SENT;
                  r.sent_value = pred_sample;
               end
               MODE_WAIT: begin
                  if (pred_expired) begin
                     if (pred_resends >= pred_cfg.try_limit) begin
                        // give up: timer left alone, expiry stays set
                        pred_mode = MODE_END;
                        r.event_res = EV_GIVEUP;
                     end else begin
                        pred_resends = pred_resends + 1'b1;
                        r.event_res = EV_SENT;
                        r.sent_value = pred_sample;
                        pred_timer = pred_cfg.ack_timeout;
                        pred_expired = (pred_cfg.ack_timeout == '0);
                     end
                  end
               end
               MODE_END: begin
                  pred_mode = MODE_IDLE;
                  pred_resends = '0;
                  r.event_res = EV_CLOSED;
               end
               default: ;
            endcase
         end
         default: ;
      endcase
      r.tries_used = pred_resends;
      return r;
   endfunction

   // follow every accepted transfer on the input and register channels
   always @(posedge clock) begin
      req_item_type it;
      if (reset) begin
         pred_mode = MODE_IDLE;
         pred_sample = '0;
         pred_resends = '0;
         pred_timer = '0;
         pred_expired = 1'b0;
         pred_cfg.try_limit = TRY_LIMIT_RST;
         pred_cfg.first_delay = FIRST_DELAY_RST;
         pred_cfg.ack_timeout = ACK_TIMEOUT_RST;
      end else begin
         if (req_tvalid && req_tready) begin
            it.op = req_tuser;
            it.cmd_length = req_tdata[5:0];
            it.cmd_text = req_tdata[45:6];
            it.adc_sample = req_tdata[57:46];
            expected_events.push_back(next_link_event(it));
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TRY_LIMIT:   pred_cfg.try_limit = csr_data[TRIES_BITS-1:0];
               CSR_FIRST_DELAY: pred_cfg.first_delay = csr_data;
               CSR_ACK_TIMEOUT: pred_cfg.ack_timeout = csr_data;
               default: ;
            endcase
         end
      end
   end

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) $display("%0t ns: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: event %0d data %0h",
                                      rsp_tuser, rsp_tdata));
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser !== want.event_res)
               report_mismatch($sformatf("event_res got %0d want %0d",
                                         rsp_tuser, want.event_res));
            if (rsp_tdata[11:0] !== want.sent_value)
               report_mismatch($sformatf("sent_value got %0h want %0h",
                                         rsp_tdata[11:0], want.sent_value));
            if (rsp_tdata[19:12] !== want.tries_used)
               report_mismatch($sformatf("tries_used got %0d want %0d",
                                         rsp_tdata[19:12], want.tries_used));
         end
      end
   end

   function automatic req_item_type make_item(input logic [OP_BITS-1:0] op,
                                              input logic [LEN_BITS-1:0] len,
                                              input logic [TEXT_BITS-1:0] text,
                                              input logic [SAMPLE_BITS-1:0] adc);
      req_item_type it;
      it.op = op;
      it.cmd_length = len;
      it.cmd_text = text;
      it.adc_sample = adc;
      return it;
   endfunction

   // valid stays high after the transfer; a gap or drain lowers it later
   task automatic send_item(input req_item_type it);
      if (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {6'd0, it.adc_sample, it.cmd_text, it.cmd_length};
      req_tuser <= it.op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_events.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed_cases();
      gap_pct = 0;
      stall_pct = 0;
      // default registers straight after reset
      send_item(make_item(OP_CMD, LEN_RST, TEXT_RST, 12'hFFF));
      send_item(make_item(OP_POLL, '0, '0, '0));
      send_item(make_item(OP_POLL, '1, '1, '1));
      send_item(make_item(OP_TICK, '1, '1, '1));
      send_item(make_item(OP_CMD, LEN_OK, {8'hA5, TEXT_OK}, '0));
      send_item(make_item(OP_POLL, '0, '0, '0));
      send_item(make_item(OP_POLL, '0, '0, '0));
      send_item(make_item(OP_UNUSED, '1, '1, '1));
      // malformed commands
      send_item(make_item(OP_CMD, '0, '0, '0));
      send_item(make_item(OP_CMD, 6'd32, '1, '1));
      send_item(make_item(OP_CMD, LEN_OK, {8'h00, TEXT_OK ^ 32'h8000_0000}, '0));
      send_item(make_item(OP_CMD, LEN_RST, TEXT_RST ^ 40'h80_0000_0000, '0));
      send_item(make_item(OP_CMD, LEN_OK, TEXT_RST, '0));
      send_item(make_item(OP_CMD, LEN_RST, {8'h00, TEXT_OK}, '0));
      send_item(make_item(OP_CMD, 6'd3, {8'h00, TEXT_OK}, '0));
      drain();
      // zero first delay expires at once; zero try limit gives up on first expiry
      write_reg(CSR_TRY_LIMIT, 16'd0);
      write_reg(CSR_FIRST_DELAY, 16'd0);
      send_item(make_item(OP_CMD, LEN_RST, TEXT_RST, 12'h000));
      send_item(make_item(OP_TICK, '0, '0, '0));
      send_item(make_item(OP_POLL, '0, '0, '0));
      send_item(make_item(OP_POLL, '0, '0, '0));
      // request while giving up restarts the session
      send_item(make_item(OP_CMD, LEN_RST, TEXT_RST, 12'h5A5));
      send_item(make_item(OP_POLL, '0, '0, '0));
      send_item(make_item(OP_POLL, '0, '0, '0));
      send_item(make_item(OP_CMD, LEN_OK, {8'h00, TEXT_OK}, '0));
      send_item(make_item(OP_POLL, '0, '0, '0));
      drain();
   endtask

   task automatic test_resend_exhaustion();
      gap_pct = 33;
      stall_pct = 33;
      write_reg(CSR_TRY_LIMIT, 16'd255);
      write_reg(CSR_FIRST_DELAY, 16'd1);
      write_reg(CSR_ACK_TIMEOUT, 16'd1);
      send_item(make_item(OP_CMD, LEN_RST, TEXT_RST, 12'h3C7));
      send_item(make_item(OP_POLL, '0, '0, '0));
      repeat (3) begin
         send_item(make_item(OP_TICK, '0, '0, '0));
         send_item(make_item(OP_POLL, '0, '0, '0));
      end
      // restart mid-session; tries carry over
      send_item(make_item(OP_CMD, LEN_RST, TEXT_RST, 12'h812));
      send_item(make_item(OP_POLL, '0, '0, '0));
      repeat (253) begin
         send_item(make_item(OP_TICK, '0, '0, '0));
         send_item(make_item(OP_POLL, '0, '0, '0));
      end
      send_item(make_item(OP_POLL, '0, '0, '0));
      drain();
   endtask

   task automatic test_random_traffic();
      req_item_type it;
      logic [63:0] r64;
      int pick;
      int count;
      for (int phase = 0; phase < 5; phase++) begin
         count = 300;
         case (phase)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
               write_reg(CSR_TRY_LIMIT, 16'd2);
               write_reg(CSR_FIRST_DELAY, 16'd3);
               write_reg(CSR_ACK_TIMEOUT, 16'd2);
            end
            1: begin
               gap_pct = 50;
               stall_pct = 0;
               write_reg(CSR_TRY_LIMIT, 16'($urandom_range(4, 0)));
               write_reg(CSR_FIRST_DELAY, 16'($urandom_range(5, 1)));
               write_reg(CSR_ACK_TIMEOUT, 16'($urandom_range(5, 1)));
            end
            2: begin
               gap_pct = 0;
               stall_pct = 50;
               write_reg(CSR_TRY_LIMIT, 16'($urandom_range(6, 0)));
               write_reg(CSR_FIRST_DELAY, 16'($urandom_range(6, 1)));
               write_reg(CSR_ACK_TIMEOUT, 16'($urandom_range(6, 1)));
            end
            3: begin
               gap_pct = 33;
               stall_pct = 33;
               write_reg(CSR_TRY_LIMIT, 16'd1);
               write_reg(CSR_FIRST_DELAY, 16'd2);
               write_reg(CSR_ACK_TIMEOUT, 16'd4);
            end
            default: begin
               // largest delays; spare index must be ignored
               count = 100;
               gap_pct = 0;
               stall_pct = 50;
               write_reg(CSR_SPARE, 16'($urandom));
               write_reg(CSR_TRY_LIMIT, 16'($urandom));
               write_reg(CSR_FIRST_DELAY, 16'hFFFF);
               write_reg(CSR_ACK_TIMEOUT, 16'hFFFF);
            end
         endcase
         for (int n = 0; n < count; n++) begin
            r64 = {$urandom, $urandom};
            it = make_item(OP_TICK, 6'($urandom_range(32, 0)), r64[39:0], r64[51:40]);
            pick = $urandom_range(99, 0);
            if (pick < 6) begin
               it.op = OP_CMD;
               it.cmd_length = LEN_RST;
               it.cmd_text = TEXT_RST;
            end else if (pick < 11) begin
               it.op = OP_CMD;
               it.cmd_length = LEN_OK;
               it.cmd_text[31:0] = TEXT_OK;
            end else if (pick < 16) begin
               // near miss: one flipped bit inside the compared bytes
               it.op = OP_CMD;
               if ($urandom_range(1, 0) == 0) begin
                  it.cmd_length = LEN_OK;
                  it.cmd_text[31:0] = TEXT_OK;
                  it.cmd_text[$urandom_range(31, 0)] ^= 1'b1;
               end else begin
                  it.cmd_length = LEN_RST;
                  it.cmd_text = TEXT_RST;
                  it.cmd_text[$urandom_range(39, 0)] ^= 1'b1;
               end
            end else if (pick < 20) begin
               it.op = OP_CMD;
            end else if (pick < 23) begin
               it.op = OP_UNUSED;
            end else if (pick < 60) begin
               it.op = OP_TICK;
            end else begin
               it.op = OP_POLL;
            end
            send_item(it);
         end
         drain();
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_cases();
      test_resend_exhaustion();
      test_random_traffic();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_events.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
